// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the pixel counting sort block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define PCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define PCS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/pcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and helpers of the pixel counting sort block.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int FrameWidth  = 320;
  localparam int FrameHeight = 200;
  localparam int NumColors   = 256;

  localparam int ColorW  = 8;
  localparam int SlotW   = 16;
  localparam int AddrW   = 32;
  localparam int StrideW = 10;
  localparam int RowW    = 8;
  localparam int ColW    = 9;
  localparam int ProdW   = RowW + StrideW;
  localparam int IdxW    = (NumColors > 1) ? $clog2(NumColors) : 1;
  localparam int CntW    = $clog2(NumColors + 1);
  localparam int PaddrW  = 3;

  localparam logic [StrideW-1:0] StrideReset = StrideW'(320);
  localparam logic [AddrW-1:0]   BaseReset   = '0;

  // Register indexes, selected by paddr bit 2.
  localparam logic RegRowStride   = 1'b0;
  localparam logic RegBaseAddress = 1'b1;

  // Item operations.
  localparam logic OpCount = 1'b0;
  localparam logic OpPlace = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_SWEEP
  } pcs_state_e;

  typedef struct packed {
    logic [StrideW-1:0] row_stride;
    logic [AddrW-1:0]   base_address;
  } cfg_t;

  // Colors beyond the palette fold onto the last color.
  function automatic logic [IdxW-1:0] clamp_color(input logic [ColorW-1:0] c);
    logic [CntW:0] wide;
    wide = (CntW+1)'(c);
    if (wide >= (CntW+1)'(NumColors)) begin
      return IdxW'(NumColors - 1);
    end
    return IdxW'(c);
  endfunction

endpackage

// ===== design/pcs_ram.sv =====
// ----------------------------------------------------------------------------
// pcs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pcs_ram #(
  parameter int Depth = 256,
  parameter int Width = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  logic [Width-1:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output logic [Width-1:0]               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/pcs_cfg.sv =====
// ----------------------------------------------------------------------------
// pcs_cfg
// APB-style configuration registers: row stride and screen base address.
// ----------------------------------------------------------------------------
module pcs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pcs_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output pcs_pkg::cfg_t              cfg_o
);

  logic [pcs_pkg::StrideW-1:0] row_stride_q, row_stride_d;
  logic [pcs_pkg::AddrW-1:0]   base_address_q, base_address_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    row_stride_d   = row_stride_q;
    base_address_d = base_address_q;
    if (wr_en) begin
      unique case (paddr[2])
        pcs_pkg::RegRowStride:   row_stride_d   = pwdata[pcs_pkg::StrideW-1:0];
        pcs_pkg::RegBaseAddress: base_address_d = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q   <= pcs_pkg::StrideReset;
      base_address_q <= pcs_pkg::BaseReset;
    end else begin
      row_stride_q   <= row_stride_d;
      base_address_q <= base_address_d;
    end
  end

  always_comb begin
    unique case (paddr[2])
      pcs_pkg::RegRowStride:   prdata = 32'(row_stride_q);
      pcs_pkg::RegBaseAddress: prdata = base_address_q;
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o.row_stride   = row_stride_q;
  assign cfg_o.base_address = base_address_q;

endmodule

// ===== design/pixel_counting_sort_by_color_unit.sv =====
// ----------------------------------------------------------------------------
// Pixel counting sort by color, driven by count and place requests.
// A place result passes through stage 1 and then the output register.
// The first place request of a frame waits for the histogram sweep.
// Reset empties the histogram.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_counting_sort_by_color_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [pcs_pkg::ColorW-1:0]     pixel_color_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pcs_pkg::SlotW-1:0]      sorted_slot_o,
  output logic [pcs_pkg::AddrW-1:0]      screen_address_o,
  output logic                           last_pixel_o,
  // Configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcs_pkg::PaddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  pcs_pkg::cfg_t cfg;

  pcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // --------------------------------------------------------------------------
  // Declarations.
  // --------------------------------------------------------------------------
  pcs_pkg::pcs_state_e state_q, state_d;

  logic                          phase_q, phase_d;
  logic [pcs_pkg::RowW-1:0]      row_q, row_d;
  logic [pcs_pkg::ColW-1:0]      col_q, col_d;
  logic [pcs_pkg::NumColors-1:0] hist_valid_q;

  // Stage 1: the request whose RAM read data is available this cycle.
  logic                          s1_valid_q;
  logic                          s1_op_q;
  logic [pcs_pkg::IdxW-1:0]      s1_idx_q;
  logic [pcs_pkg::ProdW-1:0]     s1_prod_q;
  logic [pcs_pkg::ColW-1:0]      s1_col_q;
  logic                          s1_last_q;

  // Last read-modify-write, forwarded to a back-to-back access of the entry.
  logic                          fwd_valid_q;
  logic                          fwd_op_q;
  logic [pcs_pkg::IdxW-1:0]      fwd_idx_q;
  logic [pcs_pkg::SlotW-1:0]     fwd_data_q;

  // Prefix-sum sweep.
  logic [pcs_pkg::CntW-1:0]      sw_cnt_q;
  logic                          swb_valid_q;
  logic [pcs_pkg::IdxW-1:0]      swb_idx_q;
  logic [pcs_pkg::SlotW-1:0]     sum_q;

  // Output register.
  logic                          out_valid_q;
  logic [pcs_pkg::SlotW-1:0]     out_slot_q;
  logic [pcs_pkg::AddrW-1:0]     out_addr_q;
  logic                          out_last_q;

  logic                          run_mode;
  logic                          sweep_issue;
  logic                          sweep_done;
  logic                          start_sweep;
  logic                          s1_adv;
  logic                          s1_hold;
  logic                          in_fire;
  logic                          new_frame;
  logic [pcs_pkg::IdxW-1:0]      in_idx;
  logic                          fwd_hit;

  logic [pcs_pkg::IdxW-1:0]      hist_raddr;
  logic [pcs_pkg::SlotW-1:0]     hist_rdata;
  logic                          hist_we;
  logic [pcs_pkg::SlotW-1:0]     hist_old;
  logic [pcs_pkg::SlotW-1:0]     hist_new;

  logic [pcs_pkg::IdxW-1:0]      cur_raddr;
  logic [pcs_pkg::SlotW-1:0]     cur_rdata;
  logic                          cur_we;
  logic [pcs_pkg::IdxW-1:0]      cur_waddr;
  logic [pcs_pkg::SlotW-1:0]     cur_wdata;
  logic [pcs_pkg::SlotW-1:0]     slot;
  logic [pcs_pkg::SlotW-1:0]     sweep_term;

  // --------------------------------------------------------------------------
  // Sequencer. In run mode requests flow through the read-modify-write
  // stage; the sweep state turns the histogram into bucket cursors before
  // the first place request of a frame is taken.
  // --------------------------------------------------------------------------
  assign in_idx      = pcs_pkg::clamp_color(pixel_color_i);
  assign sweep_done  = swb_valid_q && (swb_idx_q == pcs_pkg::IdxW'(pcs_pkg::NumColors - 1));
  assign start_sweep = (state_q == pcs_pkg::ST_RUN) && in_valid_i &&
                       (operation_i == pcs_pkg::OpPlace) && !phase_q && !s1_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcs_pkg::ST_RUN: begin
        if (start_sweep) begin
          state_d = pcs_pkg::ST_SWEEP;
        end
      end
      pcs_pkg::ST_SWEEP: begin
        if (sweep_done) begin
          state_d = pcs_pkg::ST_RUN;
        end
      end
      default: state_d = pcs_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    run_mode    = 1'b0;
    sweep_issue = 1'b0;
    unique case (state_q)
      pcs_pkg::ST_RUN:   run_mode    = 1'b1;
      pcs_pkg::ST_SWEEP: sweep_issue = (sw_cnt_q < pcs_pkg::CntW'(pcs_pkg::NumColors));
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request handshake. A count request always completes in stage 1; a place
  // request completes when the output register is free or being drained.
  // A place request in the counting phase is held off until the sweep ends.
  // --------------------------------------------------------------------------
  assign s1_adv  = s1_valid_q && ((s1_op_q == pcs_pkg::OpCount) || !out_valid_q || out_ready_i);
  assign s1_hold = s1_valid_q && !s1_adv;

  assign in_ready_o = run_mode && (!s1_valid_q || s1_adv) &&
                      !((operation_i == pcs_pkg::OpPlace) && !phase_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign new_frame  = in_fire && (operation_i == pcs_pkg::OpCount) && phase_q;

  // Frame position and phase. The row product is registered in stage 1, ahead
  // of the address add in the output register.
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    if (sweep_done || new_frame) begin
      row_d = '0;
      col_d = '0;
    end else if (in_fire && (operation_i == pcs_pkg::OpPlace)) begin
      if (col_q == pcs_pkg::ColW'(pcs_pkg::FrameWidth - 1)) begin
        col_d = '0;
        if (row_q == pcs_pkg::RowW'(pcs_pkg::FrameHeight - 1)) begin
          row_d = '0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
    if (sweep_done) begin
      phase_d = 1'b1;
    end else if (new_frame) begin
      phase_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::ST_RUN;
      phase_q <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
    end
  end

  // Histogram entries that are not marked valid read as zero. Starting a new
  // frame clears every mark at once instead of sweeping the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_valid_q <= '0;
    end else if (new_frame) begin
      hist_valid_q <= '0;
    end else if (hist_we) begin
      hist_valid_q[s1_idx_q] <= 1'b1;
    end
  end

  // Stage 1 control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= operation_i;
      s1_idx_q  <= in_idx;
      s1_prod_q <= pcs_pkg::ProdW'(row_q) * pcs_pkg::ProdW'(cfg.row_stride);
      s1_col_q  <= col_q;
      s1_last_q <= (row_q == pcs_pkg::RowW'(pcs_pkg::FrameHeight - 1)) &&
                   (col_q == pcs_pkg::ColW'(pcs_pkg::FrameWidth - 1));
    end
  end

  // --------------------------------------------------------------------------
  // Histogram RAM. Count requests read the entry when accepted and write the
  // saturated increment in the next cycle. A stalled place request keeps the
  // read address of stage 1 so the read data stays current.
  // --------------------------------------------------------------------------
  always_comb begin
    if (sweep_issue) begin
      hist_raddr = sw_cnt_q[pcs_pkg::IdxW-1:0];
    end else if (s1_hold) begin
      hist_raddr = s1_idx_q;
    end else begin
      hist_raddr = in_idx;
    end
  end

  assign fwd_hit = fwd_valid_q && (fwd_op_q == s1_op_q) && (fwd_idx_q == s1_idx_q);

  always_comb begin
    if (fwd_hit) begin
      hist_old = fwd_data_q;
    end else if (hist_valid_q[s1_idx_q]) begin
      hist_old = hist_rdata;
    end else begin
      hist_old = '0;
    end
    hist_new = (hist_old == '1) ? hist_old : hist_old + 1'b1;
  end

  assign hist_we = s1_valid_q && (s1_op_q == pcs_pkg::OpCount);

  pcs_ram #(
    .Depth (pcs_pkg::NumColors),
    .Width (pcs_pkg::SlotW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_idx_q),
    .wdata_i (hist_new),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // --------------------------------------------------------------------------
  // Cursor RAM. The sweep writes each exclusive prefix sum in the cycle after the
  // matching histogram read; place requests read the cursor and write it
  // back incremented. Both never happen in the same cycle.
  // --------------------------------------------------------------------------
  assign cur_raddr = s1_hold ? s1_idx_q : in_idx;
  assign slot      = fwd_hit ? fwd_data_q : cur_rdata;

  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = s1_idx_q;
    cur_wdata = slot + 1'b1;
    if (s1_adv && (s1_op_q == pcs_pkg::OpPlace)) begin
      cur_we = 1'b1;
    end else if (swb_valid_q) begin
      cur_we    = 1'b1;
      cur_waddr = swb_idx_q;
      cur_wdata = sum_q;
    end
  end

  pcs_ram #(
    .Depth (pcs_pkg::NumColors),
    .Width (pcs_pkg::SlotW)
  ) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (cur_waddr),
    .wdata_i (cur_wdata),
    .raddr_i (cur_raddr),
    .rdata_o (cur_rdata)
  );

  // The forwarding register remembers only the write of the previous edge;
  // any later read of that entry sees the RAM already updated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_op_q   <= s1_op_q;
      fwd_idx_q  <= s1_idx_q;
      fwd_data_q <= (s1_op_q == pcs_pkg::OpCount) ? hist_new : slot + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Prefix-sum sweep: one histogram entry per cycle, the running sum wraps
  // at 16 bits.
  // --------------------------------------------------------------------------
  assign sweep_term = hist_valid_q[swb_idx_q] ? hist_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_cnt_q    <= '0;
      swb_valid_q <= 1'b0;
    end else begin
      swb_valid_q <= sweep_issue;
      if (start_sweep) begin
        sw_cnt_q <= '0;
      end else if (sweep_issue) begin
        sw_cnt_q <= sw_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_issue) begin
      swb_idx_q <= sw_cnt_q[pcs_pkg::IdxW-1:0];
    end
    if (start_sweep) begin
      sum_q <= '0;
    end else if (swb_valid_q) begin
      sum_q <= sum_q + sweep_term;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It lets stage 1 finish a count request, and accept the
  // next request, while a place result waits for the consumer.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && (s1_op_q == pcs_pkg::OpPlace)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (s1_op_q == pcs_pkg::OpPlace)) begin
      out_slot_q <= slot;
      out_addr_q <= cfg.base_address + pcs_pkg::AddrW'(s1_prod_q) +
                    pcs_pkg::AddrW'(s1_col_q);
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sorted_slot_o    = out_slot_q;
  assign screen_address_o = out_addr_q;
  assign last_pixel_o     = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `PCS_ASSERT(a_no_accept_in_sweep, (state_q == pcs_pkg::ST_SWEEP) |-> !in_ready_o, "request accepted during sweep")
  `PCS_ASSERT(a_sweep_sets_phase, sweep_done |=> (phase_q && (state_q == pcs_pkg::ST_RUN)), "sweep end did not enter placing phase")
  `PCS_ASSERT(a_place_needs_cursors, (s1_valid_q && (s1_op_q == pcs_pkg::OpPlace)) |-> phase_q, "place request without cursors")
  `PCS_ASSERT(a_stall_holds_entry, s1_hold |=> (s1_valid_q && $stable(s1_idx_q)), "stalled stage 1 lost its entry")

endmodule
